>>> sv/svl_pkg.sv
`default_nettype none
package svl_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] entry_count;
  } out_item_t;

  typedef enum logic {
    PH_IDLE,
    PH_COMMIT
  } phase_t;

  typedef struct packed {
    logic               capture;
    logic               commit_ins;
    logic               commit_rem;
    logic signed [31:0] cmp_value;
    logic signed [31:0] ins_value;
  } cell_cmd_t;

endpackage
`default_nettype wire

>>> sv/svl_cell.sv
`default_nettype none
module svl_cell #(
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  wire logic                clk,
  input  wire svl_pkg::cell_cmd_t  cmd,
  input  wire logic [CNT_W-1:0]    count,
  input  wire logic signed [31:0]  prev_entry,
  input  wire logic                prev_gt,
  input  wire logic signed [31:0]  next_entry,
  output logic signed [31:0]       entry,
  output logic                     gt,
  output logic                     hit
);

  logic signed [31:0] entry_r, entry_nxt;
  logic               gt_r, ge_r, hit_r;
  logic               occ;

  assign occ = count > CNT_W'(INDEX);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      gt_r  <= !occ || (entry_r > cmd.cmp_value);
      ge_r  <= !occ || (entry_r >= cmd.cmp_value);
      hit_r <= occ && (entry_r == cmd.cmp_value);
    end
  end

  // On insert the first cell above the value loads it and the rest shift up.
  // On remove every cell from the first equal one upward takes its upper neighbor.
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.commit_ins && gt_r) begin
      if (prev_gt) begin
        entry_nxt = prev_entry;
      end else begin
        entry_nxt = cmd.ins_value;
      end
    end else if (cmd.commit_rem && ge_r) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign gt    = gt_r;
  assign hit   = hit_r;

endmodule
`default_nettype wire

>>> sv/sorted_value_list.sv
`default_nettype none
// Channel  Direction  Payload                              Handshake
// in       input      operation, item_value (in_item_t)    in_valid / in_stall
// out      output     status, entry_count (out_item_t)     out_valid / out_stall
//
// Every transaction compares the value in every cell of the chain, then shifts the
// chain and registers the result. The rate does not depend on how many entries are
// stored. Reset clears the phase, the entry count and the output valid; cell contents
// are undefined until written. A stalled output holds the chain in its commit phase,
// and one new transaction may be taken while a result waits.
module sorted_value_list #(
  parameter int CAPACITY = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire svl_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output svl_pkg::out_item_t      out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  svl_pkg::phase_t    state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [1:0]         op_r;
  logic signed [31:0] value_r;
  logic               out_valid_r;
  svl_pkg::out_item_t out_data_r, out_data_nxt;

  logic               capture, commit, slot_free, found, not_full;
  svl_pkg::cell_cmd_t cmd;

  logic signed [31:0] ent [CAPACITY];
  logic [CAPACITY-1:0] gt_v, hit_v;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      svl_pkg::PH_IDLE:   if (in_valid) state_nxt = svl_pkg::PH_COMMIT;
      svl_pkg::PH_COMMIT: if (slot_free) state_nxt = svl_pkg::PH_IDLE;
      default:            state_nxt = svl_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    capture  = 1'b0;
    commit   = 1'b0;
    case (state_r)
      svl_pkg::PH_IDLE: begin
        in_stall = 1'b0;
        capture  = in_valid;
      end
      svl_pkg::PH_COMMIT: begin
        commit = slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svl_pkg::PH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      op_r    <= in_data.operation;
      value_r <= in_data.item_value;
    end
  end

  assign found    = |hit_v;
  assign not_full = count_r < CNT_W'(CAPACITY);

  always_comb begin
    cmd.capture    = capture;
    cmd.commit_ins = commit && (op_r == svl_pkg::OP_INSERT) && not_full;
    cmd.commit_rem = commit && (op_r == svl_pkg::OP_REMOVE) && found;
    cmd.cmp_value  = in_data.item_value;
    cmd.ins_value  = value_r;
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.commit_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.commit_rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    case (op_r)
      svl_pkg::OP_INSERT: out_data_nxt.status = not_full ? svl_pkg::ST_DONE : svl_pkg::ST_FULL;
      svl_pkg::OP_REMOVE,
      svl_pkg::OP_SEARCH: out_data_nxt.status = found ? svl_pkg::ST_DONE : svl_pkg::ST_ABSENT;
      default:            out_data_nxt.status = svl_pkg::ST_ABSENT;
    endcase
    out_data_nxt.entry_count = 7'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        count_r <= count_nxt;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] prev_entry, next_entry;
    logic               prev_gt;

    if (i == 0) begin : g_first
      assign prev_entry = '0;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_entry = ent[i-1];
      assign prev_gt    = gt_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_up
      assign next_entry = ent[i+1];
    end

    svl_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .prev_entry (prev_entry),
      .prev_gt    (prev_gt),
      .next_entry (next_entry),
      .entry      (ent[i]),
      .gt         (gt_v[i]),
      .hit        (hit_v[i])
    );
  end

endmodule
`default_nettype wire
